// ----- design/lmq_pkg.sv -----
// lmq_pkg: shared types and codes of the linked message queue.
// Beat structs, controller command and status structs, status codes.
// No dependencies.
`timescale 1ns / 1ps

package lmq_pkg;

   localparam int SLOTS_DEF     = 16;
   localparam int MSG_BYTES_DEF = 32;
   localparam int LEN_W         = 7;

   // func field of a request beat
   localparam logic FUNC_SEND = 1'b0;
   localparam logic FUNC_RECV = 1'b1;

   // kind field of a response beat
   localparam logic KIND_SEND = 1'b0;
   localparam logic KIND_RECV = 1'b1;

   // status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_SIZE     = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;
   localparam logic [1:0] STAT_NO_MORE  = 2'd3;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
      logic [7:0] msg_length;
      logic       last_byte;
   } lmq_req_type;

   typedef struct packed {
      logic             kind;
      logic [1:0]       status;
      logic [7:0]       out_byte;
      logic [LEN_W-1:0] out_length;
      logic             byte_valid;
      logic             last_result;
   } lmq_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       send_step;    // accepted send beat: start / store byte
      logic       pop_free;     // take next free-list head from link read
      logic       append_link;  // store length, terminate filled slot
      logic       append_tail;  // link old tail to filled slot
      logic       rx_start;     // read link of dummy head
      logic       rx_link;      // advance head, free old dummy
      logic       rx_len;       // latch message length, read first byte
      logic       rx_byte;      // present one message byte
      logic       set_sts;      // latch a single status result
      logic       sts_kind;
      logic [1:0] sts_code;
      logic       emit_sts;     // present latched status result
   } lmq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] send_fault;   // fault of the message this beat belongs to
      logic       send_take;    // beat starts a message and takes a slot
      logic       rx_cap_low;
      logic       queue_empty;
      logic       rsp_free;
      logic       rx_len_zero;
      logic       rx_last;
   } lmq_sts_type;

endpackage

// ----- design/lmq_ram.sv -----
// lmq_ram: generic single-write, single-read RAM with registered read.
// Used for payload, slot length and link storage. No dependencies.
`timescale 1ns / 1ps

module lmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/lmq_ctrl.sv -----
// lmq_ctrl: sequencing state machine of the linked message queue.
// Drives lmq_cmd_type from request beats and lmq_sts_type. Uses lmq_pkg.
`timescale 1ns / 1ps

module lmq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lmq_pkg::lmq_req_type req_data,
   input  lmq_pkg::lmq_sts_type sts,
   output lmq_pkg::lmq_cmd_type cmd
);

   import lmq_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_POP      = 8'b0000_0010,
      S_APP_LINK = 8'b0000_0100,
      S_APP_TAIL = 8'b0000_1000,
      S_EMIT     = 8'b0001_0000,
      S_RX_LINK  = 8'b0010_0000,
      S_RX_LEN   = 8'b0100_0000,
      S_RX_BYTE  = 8'b1000_0000
   } lmq_state_type;

   lmq_state_type state_ff, state_in;
   logic          last_ff, last_in;   // last_byte of the beat being finished

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      last_in  = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.func == FUNC_SEND) begin
                  cmd.send_step = 1'b1;
                  last_in       = req_data.last_byte;
                  if (sts.send_take) begin
                     state_in = S_POP;
                  end else if (req_data.last_byte) begin
                     if (sts.send_fault == STAT_OK) begin
                        state_in = S_APP_LINK;
                     end else begin
                        cmd.set_sts  = 1'b1;
                        cmd.sts_kind = KIND_SEND;
                        cmd.sts_code = sts.send_fault;
                        state_in     = S_EMIT;
                     end
                  end
               end else if (sts.rx_cap_low) begin
                  cmd.set_sts  = 1'b1;
                  cmd.sts_kind = KIND_RECV;
                  cmd.sts_code = STAT_SIZE;
                  state_in     = S_EMIT;
               end else if (sts.queue_empty) begin
                  cmd.set_sts  = 1'b1;
                  cmd.sts_kind = KIND_RECV;
                  cmd.sts_code = STAT_NO_MORE;
                  state_in     = S_EMIT;
               end else begin
                  cmd.rx_start = 1'b1;
                  state_in     = S_RX_LINK;
               end
            end
         end
         S_POP: begin
            cmd.pop_free = 1'b1;
            state_in     = last_ff ? S_APP_LINK : S_IDLE;
         end
         S_APP_LINK: begin
            cmd.append_link = 1'b1;
            state_in        = S_APP_TAIL;
         end
         S_APP_TAIL: begin
            cmd.append_tail = 1'b1;
            cmd.set_sts     = 1'b1;
            cmd.sts_kind    = KIND_SEND;
            cmd.sts_code    = STAT_OK;
            state_in        = S_EMIT;
         end
         S_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit_sts = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RX_LINK: begin
            cmd.rx_link = 1'b1;
            state_in    = S_RX_LEN;
         end
         S_RX_LEN: begin
            if (sts.rx_len_zero) begin
               cmd.set_sts  = 1'b1;
               cmd.sts_kind = KIND_RECV;
               cmd.sts_code = STAT_OK;
               state_in     = S_EMIT;
            end else begin
               cmd.rx_len = 1'b1;
               state_in   = S_RX_BYTE;
            end
         end
         S_RX_BYTE: begin
            if (sts.rsp_free) begin
               cmd.rx_byte = 1'b1;
               if (sts.rx_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

endmodule

// ----- design/lmq_datapath.sv -----
// lmq_datapath: slot pool, list pointers, fill state and response register.
// Instantiates lmq_ram for payload, slot length and links. Uses lmq_pkg.
`timescale 1ns / 1ps

module lmq_datapath #(
   parameter int SLOTS     = lmq_pkg::SLOTS_DEF,
   parameter int MSG_BYTES = lmq_pkg::MSG_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lmq_pkg::lmq_req_type req_data,
   input  lmq_pkg::lmq_cmd_type cmd,
   output lmq_pkg::lmq_sts_type sts,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output lmq_pkg::lmq_rsp_type rsp_data
);

   import lmq_pkg::*;

   localparam int SW        = $clog2(SLOTS);
   localparam int LW        = $clog2(SLOTS + 1);
   localparam int OW        = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
   localparam int PAY_DEPTH = SLOTS * (2 ** OW);
   localparam logic [LW-1:0]    NIL     = LW'(SLOTS);
   localparam logic [7:0]       MSG_MAX = 8'(MSG_BYTES);

   // link value of a slot right after reset
   function automatic logic [LW-1:0] link_reset_value(input logic [SW-1:0] s);
      logic [LW-1:0] v;
      v = LW'(s) + LW'(1);
      if (s == '0 || v == NIL) begin
         v = NIL;
      end
      return v;
   endfunction

   // list and fill registers
   logic [SW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [LW-1:0]    free_top_ff, free_top_in;
   logic [SW-1:0]    fill_slot_ff, fill_slot_in;
   logic [LEN_W-1:0] fill_cnt_ff, fill_cnt_in, fill_lim_ff, fill_lim_in;
   logic             filling_ff, filling_in;
   logic [1:0]       fault_ff, fault_in;
   // pending status result
   logic             sts_kind_ff, sts_kind_in;
   logic [1:0]       sts_code_ff, sts_code_in;
   // receive stream
   logic [LEN_W-1:0] rx_len_ff, rx_len_in, rx_idx_ff, rx_idx_in;
   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   lmq_rsp_type      rsp_ff, rsp_in;
   // link store reset emulation
   logic [SLOTS-1:0] link_vld_ff, link_vld_in;
   logic             link_hit_ff;
   logic [LW-1:0]    link_def_ff;

   // memory ports
   logic                pay_wr_en, pay_rd_en;
   logic [SW+OW-1:0]    pay_wr_addr, pay_rd_addr;
   logic [7:0]          pay_q;
   logic                lnk_wr_en, lnk_rd_en;
   logic [SW-1:0]       lnk_wr_addr, lnk_rd_addr;
   logic [LW-1:0]       lnk_wr_data, lnk_ram_q, link_q;
   logic                slen_wr_en, slen_rd_en;
   logic [SW-1:0]       slen_rd_addr;
   logic [LEN_W-1:0]    slen_q;

   // send decode
   logic             start, free_empty, byte_wr;
   logic [1:0]       fault_now;
   logic [LEN_W-1:0] cnt_now, lim_now, rd_idx, idx_next;
   logic [SW-1:0]    wslot;

   assign link_q     = link_hit_ff ? lnk_ram_q : link_def_ff;
   assign start      = !filling_ff;
   assign free_empty = (free_top_ff == NIL);
   assign idx_next   = LEN_W'(rx_idx_ff + LEN_W'(1));

   always_comb begin
      if (start) begin
         if (req_data.msg_length > MSG_MAX) begin
            fault_now = STAT_SIZE;
         end else if (free_empty) begin
            fault_now = STAT_FULL;
         end else begin
            fault_now = STAT_OK;
         end
         cnt_now = '0;
         lim_now = req_data.msg_length[LEN_W-1:0];
         wslot   = free_top_ff[SW-1:0];
      end else begin
         fault_now = fault_ff;
         cnt_now   = fill_cnt_ff;
         lim_now   = fill_lim_ff;
         wslot     = fill_slot_ff;
      end
      byte_wr = cmd.send_step && (fault_now == STAT_OK) && (cnt_now < lim_now);
   end

   always_comb begin
      sts.send_fault  = fault_now;
      sts.send_take   = start && (fault_now == STAT_OK);
      sts.rx_cap_low  = (req_data.msg_length < MSG_MAX);
      sts.queue_empty = (head_ff == tail_ff);
      sts.rsp_free    = !rsp_valid_ff || rsp_ready;
      sts.rx_len_zero = (slen_q == '0);
      sts.rx_last     = (idx_next == rx_len_ff);
   end

   // memory port steering
   always_comb begin
      pay_wr_en   = byte_wr;
      pay_wr_addr = {wslot, cnt_now[OW-1:0]};
      rd_idx      = cmd.rx_len ? '0 : idx_next;
      pay_rd_en   = cmd.rx_len || (cmd.rx_byte && !sts.rx_last);
      pay_rd_addr = {head_ff, rd_idx[OW-1:0]};

      lnk_rd_en   = (cmd.send_step && sts.send_take) || cmd.rx_start;
      lnk_rd_addr = cmd.rx_start ? head_ff : free_top_ff[SW-1:0];
      lnk_wr_en   = cmd.append_link || cmd.append_tail || cmd.rx_link;
      lnk_wr_addr = fill_slot_ff;
      lnk_wr_data = NIL;
      if (cmd.append_tail) begin
         lnk_wr_addr = tail_ff;
         lnk_wr_data = LW'(fill_slot_ff);
      end else if (cmd.rx_link) begin
         lnk_wr_addr = head_ff;
         lnk_wr_data = free_top_ff;
      end

      slen_wr_en   = cmd.append_link;
      slen_rd_en   = cmd.rx_link;
      slen_rd_addr = link_q[SW-1:0];
   end

   // next state of registers
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      free_top_in  = free_top_ff;
      fill_slot_in = fill_slot_ff;
      fill_cnt_in  = fill_cnt_ff;
      fill_lim_in  = fill_lim_ff;
      filling_in   = filling_ff;
      fault_in     = fault_ff;
      sts_kind_in  = sts_kind_ff;
      sts_code_in  = sts_code_ff;
      rx_len_in    = rx_len_ff;
      rx_idx_in    = rx_idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      link_vld_in  = link_vld_ff;

      if (cmd.send_step) begin
         filling_in  = !req_data.last_byte;
         fault_in    = fault_now;
         fill_cnt_in = cnt_now + LEN_W'(byte_wr);
         if (sts.send_take) begin
            fill_slot_in = free_top_ff[SW-1:0];
            fill_lim_in  = lim_now;
         end
      end
      if (cmd.pop_free) begin
         free_top_in = link_q;
      end
      if (cmd.append_tail) begin
         tail_in = fill_slot_ff;
      end
      if (cmd.rx_link) begin
         head_in     = link_q[SW-1:0];
         free_top_in = LW'(head_ff);
      end
      if (lnk_wr_en) begin
         link_vld_in[lnk_wr_addr] = 1'b1;
      end
      if (cmd.set_sts) begin
         sts_kind_in = cmd.sts_kind;
         sts_code_in = cmd.sts_code;
      end
      if (cmd.rx_len) begin
         rx_len_in = slen_q;
         rx_idx_in = '0;
      end
      if (cmd.emit_sts) begin
         rsp_valid_in       = 1'b1;
         rsp_in.kind        = sts_kind_ff;
         rsp_in.status      = sts_code_ff;
         rsp_in.out_byte    = '0;
         rsp_in.out_length  = '0;
         rsp_in.byte_valid  = 1'b0;
         rsp_in.last_result = 1'b1;
      end else if (cmd.rx_byte) begin
         rsp_valid_in       = 1'b1;
         rsp_in.kind        = KIND_RECV;
         rsp_in.status      = STAT_OK;
         rsp_in.out_byte    = pay_q;
         rsp_in.out_length  = rx_len_ff;
         rsp_in.byte_valid  = 1'b1;
         rsp_in.last_result = sts.rx_last;
         rx_idx_in          = idx_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         free_top_ff  <= LW'(1);
         fill_slot_ff <= '0;
         fill_cnt_ff  <= '0;
         filling_ff   <= 1'b0;
         fault_ff     <= STAT_OK;
         rsp_valid_ff <= 1'b0;
         link_vld_ff  <= '0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_top_ff  <= free_top_in;
         fill_slot_ff <= fill_slot_in;
         fill_cnt_ff  <= fill_cnt_in;
         filling_ff   <= filling_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
         link_vld_ff  <= link_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_lim_ff <= fill_lim_in;
      sts_kind_ff <= sts_kind_in;
      sts_code_ff <= sts_code_in;
      rx_len_ff   <= rx_len_in;
      rx_idx_ff   <= rx_idx_in;
      rsp_ff      <= rsp_in;
      if (lnk_rd_en) begin
         link_hit_ff <= link_vld_ff[lnk_rd_addr];
         link_def_ff <= link_reset_value(lnk_rd_addr);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   lmq_ram #(.WIDTH(8), .DEPTH(PAY_DEPTH)) u_payload (
      .clock   (clock),
      .wr_en   (pay_wr_en),
      .wr_addr (pay_wr_addr),
      .wr_data (req_data.data_byte),
      .rd_en   (pay_rd_en),
      .rd_addr (pay_rd_addr),
      .rd_data (pay_q)
   );

   lmq_ram #(.WIDTH(LEN_W), .DEPTH(SLOTS)) u_slot_len (
      .clock   (clock),
      .wr_en   (slen_wr_en),
      .wr_addr (fill_slot_ff),
      .wr_data (fill_cnt_ff),
      .rd_en   (slen_rd_en),
      .rd_addr (slen_rd_addr),
      .rd_data (slen_q)
   );

   lmq_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link (
      .clock   (clock),
      .wr_en   (lnk_wr_en),
      .wr_addr (lnk_wr_addr),
      .wr_data (lnk_wr_data),
      .rd_en   (lnk_rd_en),
      .rd_addr (lnk_rd_addr),
      .rd_data (lnk_ram_q)
   );

   // free-list top is never the dummy head or the tail
   a_free_not_head: assert property (@(posedge clock) disable iff (reset)
      (free_top_ff != NIL) |-> (free_top_ff[SW-1:0] != head_ff))
      else $error("free list top is the queue head");

   a_free_not_tail: assert property (@(posedge clock) disable iff (reset)
      (free_top_ff != NIL) |-> (free_top_ff[SW-1:0] != tail_ff))
      else $error("free list top is the queue tail");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_cnt_ff <= LEN_W'(MSG_BYTES))
      else $error("fill count beyond slot size");

   a_byte_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.byte_valid) |-> (rsp_ff.out_length != '0
         && rsp_ff.kind == KIND_RECV))
      else $error("message byte without message length");

endmodule

// ----- design/linked_message_queue_unit.sv -----
// linked_message_queue_unit: top level of the linked message queue.
// Joins lmq_ctrl and lmq_datapath. Uses lmq_pkg, lmq_ram below the datapath.
`timescale 1ns / 1ps

// Channel   | Ports                          | Beat
// ----------+--------------------------------+--------------------------------------
// request   | req_valid, req_ready, req_data | one send byte or one receive request
// response  | rsp_valid, rsp_ready, rsp_data | one send status, receive status or byte
//
// Sequence: a send byte inside a message is taken in S_IDLE; the first byte of a
//   message also passes S_POP (free-list pop reads the link memory); the last byte
//   adds two link writes and a status result. A receive passes S_RX_LINK and S_RX_LEN
//   to unlink the message and read its length, then streams one byte per cycle while
//   rsp_ready stays high. Error and status results are latched and sent from S_EMIT.
// Reset: synchronous; link entries fall back to their power-up chaining through
//   per-slot valid bits cleared on reset, so no clearing pass is needed.
// Stalls: a registered response stage holds each beat; the stream pauses on a
//   low rsp_ready, and requests are taken only between items.

module linked_message_queue_unit #(
   parameter int SLOTS     = lmq_pkg::SLOTS_DEF,
   parameter int MSG_BYTES = lmq_pkg::MSG_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lmq_pkg::lmq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lmq_pkg::lmq_rsp_type rsp_data
);

   import lmq_pkg::*;

   lmq_cmd_type cmd;   // sequencer commands
   lmq_sts_type sts;   // datapath conditions

   // controller: decodes each accepted beat and walks the multi-cycle steps
   lmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: slot pool memories, list pointers and response register
   lmq_datapath #(
      .SLOTS     (SLOTS),
      .MSG_BYTES (MSG_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
